>>> design/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Word types for the COBS frame decoder and its assertion checker.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        byte_t in_byte;
        logic  continuing;
    } cfd_in_t;

    typedef struct packed {
        logic  out_valid;
        byte_t out_byte;
        logic  frame_start;
        logic  status;
    } cfd_out_t;

endpackage

>>> design/cobs_frame_decoder.sv
// A result word appears in the output register in the cycle after its input word is accepted.
// Throughput: one word per cycle while result_ready does not stall the single output register.
// A new word is taken when the output register is empty or the held result is taken in the same cycle.
// Reset (rst_n low, asynchronous) clears the decode state, the output register
// and the delimiter value, which returns to zero.
// ----------------------------------------------------------------------------
// cobs_frame_decoder
// Streaming COBS decoder with a programmable delimiter byte. Each input word
// yields one result word carrying the decoded byte and frame status.
// ----------------------------------------------------------------------------
module cobs_frame_decoder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              delimiter_we,
    input  cfd_pkg::byte_t    delimiter_wdata,
    input  logic              item_valid,
    output logic              item_ready,
    input  cfd_pkg::cfd_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output cfd_pkg::cfd_out_t result
);
    import cfd_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CODE = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    mode_t    mode_reg;
    mode_t    mode_next;
    byte_t    run_reg;
    byte_t    run_next;
    logic     header_reg;
    logic     header_next;
    byte_t    delim_reg;
    logic     valid_reg;
    cfd_out_t result_reg;
    cfd_out_t result_next;
    byte_t    code_run;
    logic     accept;

    assign item_ready   = !valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    assign code_run = (item.in_byte > delim_reg) ? item.in_byte - byte_t'(1) : item.in_byte;

    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        header_next = header_reg;
        result_next = '0;
        if (item.in_byte == delim_reg)
        begin
            if (item.continuing)
            begin
                result_next.status = 1'b1;
            end
            else
            begin
                mode_next               = MODE_CODE;
                header_next             = 1'b1;
                run_next                = '0;
                result_next.frame_start = 1'b1;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_CODE:
                begin
                    run_next = code_run;
                    if (header_reg)
                    begin
                        header_next = 1'b0;
                    end
                    else
                    begin
                        result_next.out_valid = 1'b1;
                        result_next.out_byte  = delim_reg;
                    end
                    mode_next = (code_run == '0) ? MODE_CODE : MODE_DATA;
                end
                MODE_DATA:
                begin
                    run_next              = run_reg - byte_t'(1);
                    result_next.out_valid = 1'b1;
                    result_next.out_byte  = item.in_byte;
                    mode_next = (run_reg == byte_t'(1)) ? MODE_CODE : MODE_DATA;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            run_reg    <= '0;
            header_reg <= 1'b0;
            delim_reg  <= '0;
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            if (delimiter_we)
            begin
                delim_reg <= delimiter_wdata;
            end
            if (accept)
            begin
                mode_reg   <= mode_next;
                run_reg    <= run_next;
                header_reg <= header_next;
                result_reg <= result_next;
                valid_reg  <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/cfd_checker.sv
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level assertions for the COBS frame decoder, bound to its top level.
// ----------------------------------------------------------------------------
module cfd_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input cfd_pkg::cfd_out_t result
);
    import cfd_pkg::*;

    // An accepted word always produces a result word in the next cycle.
    a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("accepted word produced no result");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> !result.out_valid && !result.frame_start)
        else $error("interrupted status with other flags");

    a_start_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_start |-> !result.out_valid && result.out_byte == '0)
        else $error("frame start with emitted byte");

    a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.out_valid |-> result.out_byte == '0)
        else $error("byte nonzero without emission");

endmodule

bind cobs_frame_decoder cfd_checker u_cfd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
